// File: hw/rtl/irn_pkg.sv
// Shared constants, types and codes of the nearest-neighbor image rotation block.
// No dependencies; every other file of the block imports this package.
package irn_pkg;

  // store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // field widths
  localparam int COORD_W = 9;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int TRIG_W  = 16;
  localparam int FRAC_W  = 14;
  localparam int OFF_W   = 11;
  localparam int SIZE_W  = 9;

  localparam int QONE  = 1 << FRAC_W;
  localparam int QHALF = 1 << (FRAC_W - 1);

  localparam int SIZE_MAX = (1 << SIZE_W) - 1;
  localparam int OFF_MIN  = -(1 << (OFF_W - 1));
  localparam int OFF_MAX  = (1 << (OFF_W - 1)) - 1;

  // reset value of both source size registers
  localparam int SRC_RESET = 256;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TRIG_W;
  localparam logic [CFG_IDX_W-1:0] CFG_COS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 2'd3;

  // item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // geometry pipeline depth after a register write
  localparam int GEO_LAT   = 3;
  localparam int GEO_CNT_W = $clog2(GEO_LAT + 1);

  // arithmetic widths
  localparam int PROD_W   = COORD_W + 1 + TRIG_W;   // size times trig
  localparam int CORNER_W = PROD_W + 1;             // rotated corner
  localparam int RND_W    = CORNER_W + 2;           // extent plus half
  localparam int U_W      = OFF_W + 1;              // output coord plus offset
  localparam int MUL_W    = U_W + TRIG_W;
  localparam int SUM_W    = MUL_W + 1;
  localparam int QUO_W    = SUM_W - FRAC_W;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
    logic [COORD_W-1:0]       eff_w;
    logic [COORD_W-1:0]       eff_h;
    logic signed [OFF_W-1:0]  off_x;
    logic signed [OFF_W-1:0]  off_y;
    logic [SIZE_W-1:0]        rot_h;
    logic [SIZE_W-1:0]        rot_w;
  } irn_geom_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } irn_mem_req_t;

endpackage

// File: hw/rtl/irn_if.sv
// Valid/ready channels of the rotation block: request words in, pixel words out.
// Depends on irn_pkg for field widths.
interface irn_req_if;
  import irn_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [CHAN_W-1:0]  blue;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  red;

  modport source (output valid, operation, row, col, blue, green, red, input ready);
  modport sink   (input valid, operation, row, col, blue, green, red, output ready);
endinterface

interface irn_rsp_if;
  import irn_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] pixel_blue;
  logic [CHAN_W-1:0] pixel_green;
  logic [CHAN_W-1:0] pixel_red;
  logic              inside_res;
  logic [SIZE_W-1:0] out_height;
  logic [SIZE_W-1:0] out_width;

  modport source (output valid, pixel_blue, pixel_green, pixel_red, inside_res,
                  out_height, out_width, input ready);
  modport sink   (input valid, pixel_blue, pixel_green, pixel_red, inside_res,
                  out_height, out_width, output ready);
endinterface

// File: hw/rtl/irn_geometry.sv
// Configuration registers and the three-stage pipeline that derives offsets and output size.
// Depends on irn_pkg.
module irn_geometry (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [irn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [irn_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output irn_pkg::irn_geom_t             geom_o,
  output logic                           busy_o
);
  import irn_pkg::*;

  function automatic logic signed [RND_W-1:0] round_q(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] q;
    logic [FRAC_W-1:0]       r;
    q = v >>> FRAC_W;
    r = v[FRAC_W-1:0];
    if (r > FRAC_W'(QHALF) || (r == FRAC_W'(QHALF) && q[0])) begin
      q = q + RND_W'(1);
    end
    return q;
  endfunction

  function automatic logic [SIZE_W-1:0] sat_size(input logic signed [RND_W-1:0] n);
    logic [SIZE_W-1:0] s;
    if (n < 0) begin
      s = '0;
    end else if (n > RND_W'(SIZE_MAX)) begin
      s = SIZE_W'(SIZE_MAX);
    end else begin
      s = n[SIZE_W-1:0];
    end
    return s;
  endfunction

  function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [RND_W-1:0] n);
    logic signed [OFF_W-1:0] s;
    if (n < RND_W'(OFF_MIN)) begin
      s = OFF_W'(OFF_MIN);
    end else if (n > RND_W'(OFF_MAX)) begin
      s = OFF_W'(OFF_MAX);
    end else begin
      s = n[OFF_W-1:0];
    end
    return s;
  endfunction

  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic [COORD_W-1:0]       src_w_q, src_h_q;
  logic [COORD_W-1:0]       eff_w, eff_h;
  logic [GEO_CNT_W-1:0]     cnt_q;

  logic signed [PROD_W-1:0] ew, eh, ec, es;
  logic signed [PROD_W-1:0] wc_q, hs_q, ws_q, hc_q;

  logic signed [CORNER_W-1:0] xs0, xs1, xs2, ys0, ys1, ys2;
  logic signed [CORNER_W-1:0] minx_d, maxx_d, miny_d, maxy_d;
  logic signed [CORNER_W-1:0] minx_q, maxx_q, miny_q, maxy_q;

  logic signed [OFF_W-1:0] off_x_q, off_y_q;
  logic [SIZE_W-1:0]       rot_h_q, rot_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= TRIG_W'(QONE);
      sin_q   <= '0;
      src_w_q <= COORD_W'(SRC_RESET);
      src_h_q <= COORD_W'(SRC_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COS:   cos_q   <= cfg_wdata_i;
        CFG_SIN:   sin_q   <= cfg_wdata_i;
        CFG_SRC_W: src_w_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_SRC_H: src_h_q <= cfg_wdata_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // hold busy while the new geometry ripples through the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= GEO_CNT_W'(GEO_LAT);
    end else if (cfg_we_i) begin
      cnt_q <= GEO_CNT_W'(GEO_LAT);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - GEO_CNT_W'(1);
    end
  end

  assign eff_w = (int'(src_w_q) > MAX_WIDTH)  ? COORD_W'(MAX_WIDTH)  : src_w_q;
  assign eff_h = (int'(src_h_q) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : src_h_q;

  assign ew = PROD_W'($signed({1'b0, eff_w}));
  assign eh = PROD_W'($signed({1'b0, eff_h}));
  assign ec = PROD_W'(cos_q);
  assign es = PROD_W'(sin_q);

  // stage 1: size times trig
  always_ff @(posedge clk_i) begin
    wc_q <= ew * ec;
    hs_q <= eh * es;
    ws_q <= ew * es;
    hc_q <= eh * ec;
  end

  // stage 2: corners and their bounds, origin included
  always_comb begin
    xs0 = CORNER_W'(hs_q);
    xs1 = CORNER_W'(wc_q) + CORNER_W'(hs_q);
    xs2 = CORNER_W'(wc_q);
    ys0 = CORNER_W'(hc_q);
    ys1 = CORNER_W'(hc_q) - CORNER_W'(ws_q);
    ys2 = -CORNER_W'(ws_q);
    minx_d = '0;
    maxx_d = '0;
    miny_d = '0;
    maxy_d = '0;
    if (xs0 < minx_d) minx_d = xs0;
    if (xs1 < minx_d) minx_d = xs1;
    if (xs2 < minx_d) minx_d = xs2;
    if (xs0 > maxx_d) maxx_d = xs0;
    if (xs1 > maxx_d) maxx_d = xs1;
    if (xs2 > maxx_d) maxx_d = xs2;
    if (ys0 < miny_d) miny_d = ys0;
    if (ys1 < miny_d) miny_d = ys1;
    if (ys2 < miny_d) miny_d = ys2;
    if (ys0 > maxy_d) maxy_d = ys0;
    if (ys1 > maxy_d) maxy_d = ys1;
    if (ys2 > maxy_d) maxy_d = ys2;
  end

  always_ff @(posedge clk_i) begin
    minx_q <= minx_d;
    maxx_q <= maxx_d;
    miny_q <= miny_d;
    maxy_q <= maxy_d;
  end

  // stage 3: round to nearest with ties to even, saturate
  always_ff @(posedge clk_i) begin
    rot_w_q <= sat_size(round_q(RND_W'(maxx_q) - RND_W'(minx_q) + RND_W'(QHALF))
                        + RND_W'(1));
    rot_h_q <= sat_size(round_q(RND_W'(maxy_q) - RND_W'(miny_q) + RND_W'(QHALF))
                        + RND_W'(1));
    off_x_q <= sat_off(round_q(RND_W'(minx_q) + RND_W'(QHALF)));
    off_y_q <= sat_off(round_q(RND_W'(miny_q) + RND_W'(QHALF)));
  end

  assign busy_o = (cnt_q != '0);

  always_comb begin
    geom_o.cos_v = cos_q;
    geom_o.sin_v = sin_q;
    geom_o.eff_w = eff_w;
    geom_o.eff_h = eff_h;
    geom_o.off_x = off_x_q;
    geom_o.off_y = off_y_q;
    geom_o.rot_h = rot_h_q;
    geom_o.rot_w = rot_w_q;
  end

endmodule

// File: hw/rtl/irn_map.sv
// Three-stage address pipeline: offset add, inverse rotation multiply, truncate and bound test.
// Depends on irn_pkg and irn_if.
module irn_map (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  irn_pkg::irn_geom_t    geom_i,
  input  logic                  busy_i,
  irn_req_if.sink               req_i,
  output irn_pkg::irn_mem_req_t mreq_o,
  output logic                  mreq_valid_o,
  input  logic                  mreq_ready_i
);
  import irn_pkg::*;

  // divide by QONE rounding toward zero
  function automatic logic signed [QUO_W-1:0] trunc_q(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] q;
    q = x >>> FRAC_W;
    if (x < 0 && x[FRAC_W-1:0] != '0) begin
      q = q + SUM_W'(1);
    end
    return q[QUO_W-1:0];
  endfunction

  logic en1, en2, en3, accept;

  logic                     vld1_q, rd1_q, wr1_q;
  logic signed [U_W-1:0]    uu1_q, vv1_q;
  logic [ADDR_W-1:0]        addr1_q;
  logic [PIX_W-1:0]         wdata1_q;
  logic                     wr_d;

  logic                     vld2_q, rd2_q, wr2_q;
  logic [ADDR_W-1:0]        addr2_q;
  logic [PIX_W-1:0]         wdata2_q;
  logic signed [MUL_W-1:0]  uu, vv, cc, ss;
  logic signed [MUL_W-1:0]  uc_q, vs_q, us_q, vc_q;

  logic signed [QUO_W-1:0]  sx, sy;
  logic                     in_src;
  logic [ADDR_W-1:0]        raddr;
  logic                     vld3_q;
  irn_mem_req_t             mreq_d, mreq_q;

  // a stage advances when it is empty or the next one takes its word
  assign en3    = !vld3_q || mreq_ready_i;
  assign en2    = !vld2_q || en3;
  assign en1    = !vld1_q || en2;
  assign req_i.ready = en1 && !busy_i;
  assign accept = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= accept;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
    end
  end

  // drop writes that fall outside the store
  assign wr_d = (req_i.operation == OP_WRITE) && (int'(req_i.row) < MAX_HEIGHT)
                && (int'(req_i.col) < MAX_WIDTH);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      rd1_q    <= (req_i.operation == OP_READ);
      wr1_q    <= wr_d;
      uu1_q    <= U_W'($signed({1'b0, req_i.col})) + U_W'(geom_i.off_x);
      vv1_q    <= U_W'($signed({1'b0, req_i.row})) + U_W'(geom_i.off_y);
      addr1_q  <= ADDR_W'(int'(req_i.row) * MAX_WIDTH + int'(req_i.col));
      wdata1_q <= {req_i.red, req_i.green, req_i.blue};
    end
  end

  assign uu = MUL_W'(uu1_q);
  assign vv = MUL_W'(vv1_q);
  assign cc = MUL_W'(geom_i.cos_v);
  assign ss = MUL_W'(geom_i.sin_v);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      rd2_q    <= rd1_q;
      wr2_q    <= wr1_q;
      addr2_q  <= addr1_q;
      wdata2_q <= wdata1_q;
      uc_q     <= uu * cc;
      vs_q     <= vv * ss;
      us_q     <= uu * ss;
      vc_q     <= vv * cc;
    end
  end

  assign sx = trunc_q(SUM_W'(uc_q) - SUM_W'(vs_q));
  assign sy = trunc_q(SUM_W'(us_q) + SUM_W'(vc_q));
  assign in_src = (sx >= 0) && (sx < $signed(QUO_W'(geom_i.eff_w)))
                  && (sy >= 0) && (sy < $signed(QUO_W'(geom_i.eff_h)));
  assign raddr = ADDR_W'(int'(sy) * MAX_WIDTH + int'(sx));

  always_comb begin
    mreq_d.rd    = rd2_q && in_src;
    mreq_d.wr    = wr2_q;
    mreq_d.addr  = rd2_q ? raddr : addr2_q;
    mreq_d.wdata = wdata2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) mreq_q <= mreq_d;
  end

  assign mreq_o       = mreq_q;
  assign mreq_valid_o = vld3_q;

endmodule

// File: hw/rtl/irn_store.sv
// Source pixel memory, single port with registered read, and the result word register.
// Depends on irn_pkg and irn_if.
module irn_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  irn_pkg::irn_geom_t    geom_i,
  input  irn_pkg::irn_mem_req_t mreq_i,
  input  logic                  mreq_valid_i,
  output logic                  mreq_ready_o,
  irn_rsp_if.source             rsp_o
);
  import irn_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;
  logic             vld_q, inside_q, take;
  logic [PIX_W-1:0] pix;

  assign mreq_ready_o = !vld_q || rsp_o.ready;
  assign take         = mreq_valid_i && mreq_ready_o;

  // one access per word, in arrival order
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (mreq_i.wr) begin
        mem[mreq_i.addr] <= mreq_i.wdata;
      end else if (mreq_i.rd) begin
        rdata_q <= mem[mreq_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) inside_q <= mreq_i.rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (mreq_ready_o) begin
      vld_q <= mreq_valid_i;
    end
  end

  assign pix = inside_q ? rdata_q : '0;

  assign rsp_o.valid       = vld_q;
  assign rsp_o.pixel_blue  = pix[CHAN_W-1:0];
  assign rsp_o.pixel_green = pix[2*CHAN_W-1:CHAN_W];
  assign rsp_o.pixel_red   = pix[3*CHAN_W-1:2*CHAN_W];
  assign rsp_o.inside_res  = inside_q;
  assign rsp_o.out_height  = geom_i.rot_h;
  assign rsp_o.out_width   = geom_i.rot_w;

endmodule

// File: hw/rtl/image_rotate_nearest_unit.sv
// Nearest-neighbor image rotation: top level. A result word comes from the memory read
// register behind the map stages; throughput is one word per cycle, set by the single
// memory port, while the result side is ready. A register write holds off requests while
// the geometry pipeline recomputes. Reset (rst_ni, async low) restores the registers and
// holds requests off likewise; the pixel memory is not cleared and reads as garbage until written.
// Depends on irn_pkg, irn_if, irn_geometry, irn_map and irn_store.
module image_rotate_nearest_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [irn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [irn_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  irn_req_if.sink                        req_i,
  irn_rsp_if.source                      rsp_o
);
  import irn_pkg::*;

  irn_geom_t    geom;
  logic         geo_busy;
  irn_mem_req_t mreq;
  logic         mreq_valid, mreq_ready;

  // Registers and derived geometry: offsets and rotated size follow each write
  // after three pipeline stages (products, corner bounds, rounding).
  irn_geometry u_geometry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom),
    .busy_o      (geo_busy)
  );

  // Map each request word to a memory access. Reads go through the inverse
  // rotation; writes carry their address along so that all accesses reach the
  // memory in request order and no forwarding is needed.
  irn_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .busy_i       (geo_busy),
    .req_i        (req_i),
    .mreq_o       (mreq),
    .mreq_valid_o (mreq_valid),
    .mreq_ready_i (mreq_ready)
  );

  // Memory and result word register; a waiting result only stalls the stages
  // behind it once they fill up.
  irn_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .mreq_i       (mreq),
    .mreq_valid_i (mreq_valid),
    .mreq_ready_o (mreq_ready),
    .rsp_o        (rsp_o)
  );

endmodule
